// File: rtl/ssps_pkg.sv
// Shared types, constants and helpers for the sleep-state package scanner.
// No dependencies.
package ssps_pkg;

    localparam int HEADER_BYTES       = 36;
    localparam int PACKAGE_TAIL_BYTES = 11;
    localparam int OUT_DEPTH          = 4;
    localparam int CFG_INDEX_W        = 2;
    localparam int TYPE_SHIFT         = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_PM1A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PM1B = 2'd1;

    localparam logic [23:0] SIG_HEAD     = 24'h5F5335;  // "_S5"
    localparam logic [7:0]  SIG_TAIL     = 8'h5F;       // "_"
    localparam logic [7:0]  PKG_OPCODE   = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX  = 8'h0A;
    localparam logic [15:0] SLEEP_ENABLE = 16'h2000;

    typedef enum logic [9:0] {
        PH_SEARCH  = 10'b00_0000_0001,
        PH_PKGOP   = 10'b00_0000_0010,
        PH_PKGLEN  = 10'b00_0000_0100,
        PH_LENTAIL = 10'b00_0000_1000,
        PH_NUMEL   = 10'b00_0001_0000,
        PH_A_PRE   = 10'b00_0010_0000,
        PH_A       = 10'b00_0100_0000,
        PH_B_PRE   = 10'b00_1000_0000,
        PH_B       = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic        found;
        logic [15:0] port_address;
        logic [15:0] control_word;
        logic        last_write;
    } result_t;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [15:0] ctl_word(input logic [7:0] sleep_type);
        logic [17:0] shifted;
        shifted = 18'(sleep_type) << TYPE_SHIFT;
        return shifted[15:0] | SLEEP_ENABLE;
    endfunction

endpackage

// File: rtl/ssps_parser.sv
// Byte-at-a-time parser: signature search window, package header skip,
// sleep type capture and result generation. Depends on ssps_pkg.
module ssps_parser
    import ssps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_vld,
    input  logic [7:0]  byte_data,
    input  logic        byte_last,
    input  logic [15:0] pm1a_port,
    input  logic [15:0] pm1b_port,
    output push_t       push
);

    logic [31:0] offset_reg, offset_next;
    logic [31:0] length_reg, length_next;
    logic [23:0] recent_reg, recent_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  skip_reg, skip_next;
    logic [7:0]  type_a_reg, type_a_next;

    logic        win_ok;
    logic [32:0] win_end;
    logic [31:0] len_byte;
    push_t       res;

    assign win_end  = {1'b0, offset_reg} + 33'(PACKAGE_TAIL_BYTES - 3);
    assign win_ok   = (offset_reg >= 32'(HEADER_BYTES + 3)) && (win_end < {1'b0, length_reg});
    assign len_byte = 32'(byte_data) << {offset_reg[1:0], 3'b000};

    always_comb
    begin
        offset_next = (offset_reg == '1) ? offset_reg : offset_reg + 32'd1;
        length_next = length_reg;
        recent_next = {recent_reg[15:0], byte_data};
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        type_a_next = type_a_reg;
        res         = '0;

        // little-endian length lives in header bytes 4..7
        if (offset_reg[31:3] == '0 && offset_reg[2])
        begin
            length_next = length_reg | len_byte;
        end

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (recent_reg == SIG_HEAD && byte_data == SIG_TAIL && win_ok)
                begin
                    phase_next = PH_PKGOP;
                end
            end
            PH_PKGOP, PH_PKGLEN:
            begin
                if (phase_reg == PH_PKGOP && byte_data == PKG_OPCODE)
                begin
                    phase_next = PH_PKGLEN;
                end
                else
                begin
                    skip_next  = byte_data[7:6];
                    phase_next = (byte_data[7:6] == 2'd0) ? PH_NUMEL : PH_LENTAIL;
                end
            end
            PH_LENTAIL:
            begin
                skip_next = skip_reg - 2'd1;
                if (skip_reg == 2'd1)
                begin
                    phase_next = PH_NUMEL;
                end
            end
            PH_NUMEL:
            begin
                phase_next = PH_A_PRE;
            end
            PH_A_PRE, PH_A:
            begin
                if (phase_reg == PH_A_PRE && byte_data == BYTE_PREFIX)
                begin
                    phase_next = PH_A;
                end
                else
                begin
                    type_a_next = byte_data;
                    phase_next  = PH_B_PRE;
                end
            end
            PH_B_PRE, PH_B:
            begin
                if (phase_reg == PH_B_PRE && byte_data == BYTE_PREFIX)
                begin
                    phase_next = PH_B;
                end
                else
                begin
                    phase_next = PH_DONE;
                    res.first  = '{found: 1'b1, port_address: pm1a_port,
                                   control_word: ctl_word(type_a_reg),
                                   last_write: (pm1b_port == '0)};
                    if (pm1b_port != '0)
                    begin
                        res.second = '{found: 1'b1, port_address: pm1b_port,
                                       control_word: ctl_word(byte_data),
                                       last_write: 1'b1};
                        res.count  = 2'd2;
                    end
                    else
                    begin
                        res.count = 2'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (byte_last)
        begin
            // not-found report when nothing was written for this table
            if (res.count == 2'd0 && phase_next != PH_DONE)
            begin
                res.first = '{found: 1'b0, port_address: '0, control_word: '0,
                              last_write: 1'b1};
                res.count = 2'd1;
            end
            offset_next = '0;
            length_next = '0;
            recent_next = '0;
            phase_next  = PH_SEARCH;
            skip_next   = '0;
            type_a_next = '0;
        end

        if (!byte_vld)
        begin
            res.count = 2'd0;
        end
    end

    assign push = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            length_reg <= '0;
            recent_reg <= '0;
            phase_reg  <= PH_SEARCH;
            skip_reg   <= '0;
            type_a_reg <= '0;
        end
        else if (byte_vld)
        begin
            offset_reg <= offset_next;
            length_reg <= length_next;
            recent_reg <= recent_next;
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            type_a_reg <= type_a_next;
        end
    end

endmodule

// File: rtl/ssps_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle.
// Depends on ssps_pkg.
module ssps_out_fifo
    import ssps_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  push_t                      push,
    input  logic                       pop,
    output result_t                    head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);
    assign pop_ok   = pop && (count_reg != '0);

    always_comb
    begin
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop_ok ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.second;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: rtl/sleep_state_package_scanner.sv
// Top level: input register, configuration registers, parser and result queue.
// Latency: a byte accepted passes through the input register and is parsed, and its results are shown from the queue.
// Throughput: one byte per cycle while in_ready is high; in_ready drops when the queue,
// counting the results of the staged byte, can no longer take two more results.
// Reset (rst_n, async, active low) clears the scan state, ports and queue.
// Depends on ssps_pkg, ssps_parser, ssps_out_fifo.
module sleep_state_package_scanner
    import ssps_pkg::*;
#(
    parameter int OUT_DEPTH_P = OUT_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             table_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [15:0]            port_address,
    output logic [15:0]            control_word,
    output logic                   last_write,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH_P + 1);

    logic              stage_vld_reg;
    logic [7:0]        stage_byte_reg;
    logic              stage_last_reg;
    logic [15:0]       pm1a_reg;
    logic [15:0]       pm1b_reg;
    push_t             push;
    result_t           head;
    logic [CNT_W-1:0]  q_count;
    logic [CNT_W:0]    q_need;
    logic              in_xact;

    // room for the byte in the stage plus the next one
    assign q_need    = {1'b0, q_count} + (CNT_W + 1)'(push.count);
    assign in_ready  = q_need <= (CNT_W + 1)'(OUT_DEPTH_P - 2);
    assign in_xact   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg  <= 1'b0;
            stage_byte_reg <= '0;
            stage_last_reg <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= in_xact;
            if (in_xact)
            begin
                stage_byte_reg <= table_byte;
                stage_last_reg <= last_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm1a_reg <= '0;
            pm1b_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PM1A: pm1a_reg <= cfg_data;
                CFG_PM1B: pm1b_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    ssps_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_vld  (stage_vld_reg),
        .byte_data (stage_byte_reg),
        .byte_last (stage_last_reg),
        .pm1a_port (pm1a_reg),
        .pm1b_port (pm1b_reg),
        .push      (push)
    );

    ssps_out_fifo #(
        .DEPTH (OUT_DEPTH_P)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_ready),
        .head  (head),
        .count (q_count)
    );

    assign out_valid    = q_count != '0;
    assign found        = head.found;
    assign port_address = head.port_address;
    assign control_word = head.control_word;
    assign last_write   = head.last_write;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(OUT_DEPTH_P))
        else $error("result queue overflow");

    a_two_needs_b: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> pm1b_reg != '0)
        else $error("second write with port B absent");

    a_notfound_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last_write && port_address == '0 && control_word == '0)
        else $error("malformed not-found report");

    a_push_only_staged: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_vld_reg |-> push.count == 2'd0)
        else $error("results without a staged byte");
`endif

endmodule

// File: bench/ssps_tb_pkg.sv
`timescale 1ns / 1ps
// Sleep-write tracker for the sleep-state package scanner bench: predicts the port
// writes of each table and checks what comes out. Depends on ssps_pkg.
package ssps_tb_pkg;
    import ssps_pkg::*;

    class sleep_write_tracker;
        logic [15:0] pm1a_port;
        logic [15:0] pm1b_port;
        logic [31:0] offset;
        logic [31:0] table_len;
        logic [23:0] window;
        phase_t      phase;
        logic [2:0]  skip_left;
        logic [7:0]  first_type;
        result_t     pending_writes[$];
        int          mismatches;
        int          writes_predicted;

        function new();
            pm1a_port = '0;
            pm1b_port = '0;
            mismatches = 0;
            writes_predicted = 0;
            restart();
        endfunction

        function void restart();
            offset = '0;
            table_len = '0;
            window = '0;
            phase = PH_SEARCH;
            skip_left = '0;
            first_type = '0;
        endfunction

        function void take_config(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
            if (index == CFG_PM1A)
                pm1a_port = value;
            else if (index == CFG_PM1B)
                pm1b_port = value;
        endfunction

        function logic [15:0] sleep_word(logic [7:0] sleep_type);
            return {sleep_type[5:0], 10'd0} | SLEEP_ENABLE;
        endfunction

        function void queue_write(logic f, logic [15:0] port, logic [15:0] word, logic fin);
            result_t r;
            r.found = f;
            r.port_address = port;
            r.control_word = word;
            r.last_write = fin;
            pending_writes.push_back(r);
            writes_predicted++;
        endfunction

        // top two bits of the package length lead byte = extra length bytes
        function void take_lead(logic [7:0] b);
            skip_left = {1'b0, b[7:6]};
            phase = (b[7:6] == 2'd0) ? PH_NUMEL : PH_LENTAIL;
        endfunction

        function int emit_writes(logic [7:0] second_type);
            phase = PH_DONE;
            if (pm1b_port != 16'd0)
            begin
                queue_write(1'b1, pm1a_port, sleep_word(first_type), 1'b0);
                queue_write(1'b1, pm1b_port, sleep_word(second_type), 1'b1);
                return 2;
            end
            queue_write(1'b1, pm1a_port, sleep_word(first_type), 1'b1);
            return 1;
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            int              n;
            logic [31:0]     off;
            longint unsigned start;
            n = 0;
            off = offset;
            if (off >= 32'd4 && off <= 32'd7)
                table_len |= {24'd0, b} << (8 * (off - 32'd4));
            case (phase)
                PH_SEARCH:
                begin
                    if (off >= 32'd3 && window == SIG_HEAD && b == SIG_TAIL)
                    begin
                        start = off - 32'd3;
                        if (start >= HEADER_BYTES && start + PACKAGE_TAIL_BYTES < table_len)
                            phase = PH_PKGOP;
                    end
                end
                PH_PKGOP:
                begin
                    if (b == PKG_OPCODE)
                        phase = PH_PKGLEN;
                    else
                        take_lead(b);
                end
                PH_PKGLEN:  take_lead(b);
                PH_LENTAIL:
                begin
                    skip_left = skip_left - 3'd1;
                    if (skip_left == 3'd0)
                        phase = PH_NUMEL;
                end
                PH_NUMEL:   phase = PH_A_PRE;
                PH_A_PRE:
                begin
                    if (b == BYTE_PREFIX)
                        phase = PH_A;
                    else
                    begin
                        first_type = b;
                        phase = PH_B_PRE;
                    end
                end
                PH_A:
                begin
                    first_type = b;
                    phase = PH_B_PRE;
                end
                PH_B_PRE:
                begin
                    if (b == BYTE_PREFIX)
                        phase = PH_B;
                    else
                        n = emit_writes(b);
                end
                PH_B:       n = emit_writes(b);
                default:    phase = PH_DONE;
            endcase
            window = {window[15:0], b};
            if (offset != 32'hFFFF_FFFF)
                offset = offset + 32'd1;
            if (fin)
            begin
                if (n == 0 && phase != PH_DONE)
                    queue_write(1'b0, 16'd0, 16'd0, 1'b1);
                restart();
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("time %0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_write(result_t got);
            result_t want;
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                $display("time %0t: result with nothing pending, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_writes.pop_front();
            compare_field("found", 16'(want.found), 16'(got.found));
            compare_field("port_address", want.port_address, got.port_address);
            compare_field("control_word", want.control_word, got.control_word);
            compare_field("last_write", 16'(want.last_write), 16'(got.last_write));
        endfunction
    endclass

endpackage

// File: bench/sleep_state_package_scanner_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sleep_state_package_scanner: streams directed and random
// tables under varied idling. Depends on ssps_pkg, ssps_tb_pkg and the RTL.
module sleep_state_package_scanner_tb;
    import ssps_pkg::*;
    import ssps_tb_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_BYTES    = 80;
    localparam int PHASE_WRITES   = 2;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             table_byte;
    logic                   last_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic                   found;
    logic [15:0]            port_address;
    logic [15:0]            control_word;
    logic                   last_write;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;

    int                 in_idle_pct;
    int                 out_stall_pct;
    int                 stall_cycles;
    int                 bytes_sent;
    logic [7:0]         scan_bytes[$];
    sleep_write_tracker sb = new();

    sleep_state_package_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .table_byte   (table_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .port_address (port_address),
        .control_word (control_word),
        .last_write   (last_write),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    // observe every transaction on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.take_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.take_byte(table_byte, last_byte);
            if (out_valid && out_ready)
                sb.check_write({found, port_address, control_word, last_write});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < in_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        table_byte <= b;
        last_byte  <= fin;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_table();
        for (int i = 0; i < scan_bytes.size(); i++)
            push_byte(scan_bytes[i], i == scan_bytes.size() - 1);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // let every pending write come out, then give the pipe time to go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void add_noise(input int unsigned count);
        repeat (count) scan_bytes.push_back(8'($urandom));
    endfunction

    function automatic void begin_table(input int unsigned pre_fill);
        scan_bytes = {};
        add_noise(HEADER_BYTES + pre_fill);
        for (int i = 4; i < 8; i++)
            scan_bytes[i] = 8'd0;
    endfunction

    function automatic void place_signature(input int unsigned at);
        scan_bytes[at]     = SIG_HEAD[23:16];
        scan_bytes[at + 1] = SIG_HEAD[15:8];
        scan_bytes[at + 2] = SIG_HEAD[7:0];
        scan_bytes[at + 3] = SIG_TAIL;
    endfunction

    function automatic void add_signature();
        add_noise(4);
        place_signature(scan_bytes.size() - 4);
    endfunction

    function automatic void add_package(input bit opcode, input logic [1:0] extra,
                                        input bit pre_a, input bit pre_b,
                                        input logic [7:0] type_a, input logic [7:0] type_b);
        if (opcode)
            scan_bytes.push_back(PKG_OPCODE);
        scan_bytes.push_back({extra, 6'($urandom)});
        add_noise(extra + 1);  // extra length bytes, then element count
        if (pre_a)
            scan_bytes.push_back(BYTE_PREFIX);
        scan_bytes.push_back(type_a);
        if (pre_b)
            scan_bytes.push_back(BYTE_PREFIX);
        scan_bytes.push_back(type_b);
    endfunction

    function automatic void set_length(input logic [31:0] len);
        for (int i = 0; i < 4; i++)
            scan_bytes[4 + i] = len[8*i +: 8];
    endfunction

    task automatic random_table();
        int unsigned sig_at;
        int unsigned keep;
        int unsigned pick;
        if ($urandom_range(99) < 15)
        begin
            // pure noise, sometimes too short to hold the length field
            scan_bytes = {};
            add_noise($urandom_range(1, 50));
            if (scan_bytes.size() >= 8 && $urandom_range(1))
                set_length($urandom);
        end
        else
        begin
            begin_table($urandom_range(0, 10));
            if ($urandom_range(19) == 0)
                place_signature($urandom_range(8, 32));
            sig_at = scan_bytes.size();
            add_signature();
            add_package($urandom_range(1), 2'($urandom), $urandom_range(1), $urandom_range(1),
                        8'($urandom), 8'($urandom));
            add_noise($urandom_range(0, 10));
            pick = $urandom_range(19);
            if (pick == 0)
                set_length(sig_at + PACKAGE_TAIL_BYTES);
            else if (pick == 1)
                set_length($urandom);
            else if (pick == 2)
                set_length(sig_at + PACKAGE_TAIL_BYTES + 1);
            else
                set_length(sig_at + PACKAGE_TAIL_BYTES + 1 + $urandom_range(0, 60));
            if ($urandom_range(9) == 0)
            begin
                keep = $urandom_range(1, scan_bytes.size());
                while (scan_bytes.size() > keep)
                    void'(scan_bytes.pop_back());
            end
        end
        send_table();
    endtask

    initial
    begin
        int phase_bytes;
        int phase_writes;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        table_byte    = '0;
        last_byte     = 1'b0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        stall_cycles  = 0;
        bytes_sent    = 0;
        in_idle_pct   = 7;
        out_stall_pct = 85;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ports still at reset: a lone byte, then a table cut inside the header
        scan_bytes = {};
        add_noise(1);
        send_table();
        scan_bytes = {};
        add_noise(8);
        set_length(32'd100);
        send_table();
        settle();

        write_reg(CFG_PM1A, 16'hFFFF);
        write_reg(CFG_PM1B, 16'h0001);
        write_reg(CFG_SPARE, 16'hA5A5);

        // tightest window at the first legal offset, all optional bytes present,
        // a second signature after the writes
        begin_table(0);
        add_signature();
        add_package(1'b1, 2'd3, 1'b1, 1'b1, 8'hFF, 8'h00);
        add_signature();
        add_noise(3);
        set_length(HEADER_BYTES + PACKAGE_TAIL_BYTES + 1);
        send_table();
        // window one byte short
        begin_table(0);
        add_signature();
        add_package(1'b0, 2'd0, 1'b0, 1'b0, 8'h3F, 8'hC0);
        set_length(HEADER_BYTES + PACKAGE_TAIL_BYTES);
        send_table();
        // signature inside the header only
        begin_table(0);
        place_signature(HEADER_BYTES - 4);
        add_noise(20);
        set_length(32'hFFFF_FFFF);
        send_table();
        // stream ends after the first sleep type
        begin_table(2);
        add_signature();
        add_package(1'b1, 2'd1, 1'b1, 1'b1, 8'h05, 8'h07);
        void'(scan_bytes.pop_back());
        void'(scan_bytes.pop_back());
        set_length(32'd200);
        send_table();
        // bare first type, prefixed second type equal to the prefix value
        begin_table(5);
        add_signature();
        add_package(1'b0, 2'd2, 1'b0, 1'b1, 8'h01, BYTE_PREFIX);
        add_noise(4);
        set_length(32'd120);
        send_table();
        settle();

        for (int p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:       begin in_idle_pct = 7;  out_stall_pct = 85; end
                1:       begin in_idle_pct = 85; out_stall_pct = 7;  end
                default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
            endcase
            case (p)
                0:       begin write_reg(CFG_PM1A, 16'hFFFF); write_reg(CFG_PM1B, 16'hFFFF); end
                1:       begin write_reg(CFG_PM1A, 16'h0000); write_reg(CFG_PM1B, 16'h0000); end
                2:       begin write_reg(CFG_PM1A, 16'($urandom)); write_reg(CFG_PM1B, 16'h0); end
                3:
                begin
                    write_reg(CFG_PM1A, 16'($urandom));
                    write_reg(CFG_PM1B, 16'($urandom_range(1, 65535)));
                end
                4:       begin write_reg(CFG_PM1A, 16'hFFFF); write_reg(CFG_PM1B, 16'h0000); end
                default: begin write_reg(CFG_PM1A, 16'h0000); write_reg(CFG_PM1B, 16'hFFFF); end
            endcase
            phase_bytes  = bytes_sent;
            phase_writes = sb.writes_predicted;
            while (bytes_sent - phase_bytes < PHASE_BYTES
                   || sb.writes_predicted - phase_writes < PHASE_WRITES)
                random_table();
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
